@@ design/apci_pkg.sv @@
package apci_pkg;

    localparam int PIX_W  = 8;
    localparam int IDX_OUT_W = 8;
    localparam int DIST_W = 18;

    localparam logic [1:0] KIND_EXACT   = 2'd0;
    localparam logic [1:0] KIND_INSERT  = 2'd1;
    localparam logic [1:0] KIND_NEAREST = 2'd2;

    typedef struct packed {
        logic start;
        logic issue;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic used_zero;
        logic scan_last;
        logic pipe_empty;
        logic out_busy;
    } t_ctl_sts;

endpackage

@@ design/apci_ram.sv @@
module apci_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/apci_ctl.sv @@
module apci_ctl
    import apci_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.used_zero ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/apci_dp.sv @@
module apci_dp
    import apci_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3*PIX_W-1:0] i_pixel,
    input  t_ctl_cmd          i_cmd,
    output t_ctl_sts          o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_OUT_W-1:0] o_palette_index,
    output logic [1:0]        o_match_kind
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    logic [PIX_W-1:0]   r_red;
    logic [PIX_W-1:0]   r_green;
    logic [PIX_W-1:0]   r_blue;
    logic [CNT_W-1:0]   r_used;
    logic [IDX_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_dist_vld;
    logic [IDX_W-1:0]   r_dist_idx;
    logic [DIST_W-1:0]  r_dist;
    logic               r_best_vld;
    logic [IDX_W-1:0]   r_best_idx;
    logic [DIST_W-1:0]  r_best;
    logic               r_out_vld;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [1:0]         r_out_kind;

    logic [3*PIX_W-1:0] rd_data;
    logic [PIX_W-1:0]   d_red;
    logic [PIX_W-1:0]   d_green;
    logic [PIX_W-1:0]   d_blue;
    logic [DIST_W-1:0]  cur_dist;
    logic               exact;
    logic               insert;

    apci_ram #(
        .WIDTH (3 * PIX_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && insert),
        .i_waddr (r_used[IDX_W-1:0]),
        .i_wdata ({r_blue, r_green, r_red}),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        logic [PIX_W-1:0] m_red;
        logic [PIX_W-1:0] m_green;
        logic [PIX_W-1:0] m_blue;
        m_red    = rd_data[PIX_W-1:0];
        m_green  = rd_data[2*PIX_W-1:PIX_W];
        m_blue   = rd_data[3*PIX_W-1:2*PIX_W];
        d_red    = (r_red > m_red) ? (r_red - m_red) : (m_red - r_red);
        d_green  = (r_green > m_green) ? (r_green - m_green) : (m_green - r_green);
        d_blue   = (r_blue > m_blue) ? (r_blue - m_blue) : (m_blue - r_blue);
        cur_dist = DIST_W'(d_red) * DIST_W'(d_red) + DIST_W'(d_green) * DIST_W'(d_green)
                 + DIST_W'(d_blue) * DIST_W'(d_blue);
    end

    assign exact  = r_best_vld && (r_best == '0);
    assign insert = !exact && (r_used < CNT_W'(PALETTE_ENTRIES));

    assign o_sts.used_zero  = (r_used == '0);
    assign o_sts.scan_last  = (CNT_W'(r_addr) + CNT_W'(1)) == r_used;
    assign o_sts.pipe_empty = !r_rd_vld && !r_dist_vld;
    assign o_sts.out_busy   = r_out_vld && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_red   <= i_pixel[PIX_W-1:0];
            r_green <= i_pixel[2*PIX_W-1:PIX_W];
            r_blue  <= i_pixel[3*PIX_W-1:2*PIX_W];
            r_addr  <= '0;
        end else if (i_cmd.issue) begin
            r_addr  <= r_addr + IDX_W'(1);
        end
        r_rd_idx   <= r_addr;
        r_dist     <= cur_dist;
        r_dist_idx <= r_rd_idx;
        if (r_dist_vld && (!r_best_vld || (r_dist < r_best))) begin
            r_best     <= r_dist;
            r_best_idx <= r_dist_idx;
        end
        if (i_cmd.finish) begin
            if (exact) begin
                r_out_idx  <= IDX_OUT_W'(r_best_idx);
                r_out_kind <= KIND_EXACT;
            end else if (insert) begin
                r_out_idx  <= IDX_OUT_W'(r_used[IDX_W-1:0]);
                r_out_kind <= KIND_INSERT;
            end else begin
                r_out_idx  <= IDX_OUT_W'(r_best_idx);
                r_out_kind <= KIND_NEAREST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_rd_vld   <= 1'b0;
            r_dist_vld <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_dist_vld <= r_rd_vld;
            if (i_cmd.start) begin
                r_best_vld <= 1'b0;
            end else if (r_dist_vld) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.finish && insert) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_palette_index = r_out_idx;
    assign o_match_kind    = r_out_kind;

endmodule

@@ design/adaptive_palette_color_indexer.sv @@
// Channel   Direction  Beat contents (lowest bits first)
// s_*       in         tdata[7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue
// m_*       out        tdata[7:0] palette_index, [9:8] match_kind, [15:10] zero
//
// A pixel's search reads the palette once per used entry through one port,
// then waits for the read and distance registers to drain before its result
// is loaded; while the palette is empty the scan is skipped.
// Reset empties the palette at once; no clearing pass is needed.
// A new beat is taken while the previous result still waits on m_tready;
// a stalled result holds only the final step of the next pixel.
module adaptive_palette_color_indexer
    import apci_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // palette_index, match_kind, zero fill
);

    t_ctl_cmd             cmd;
    t_ctl_sts             sts;
    logic [IDX_OUT_W-1:0] palette_index;
    logic [1:0]           match_kind;

    apci_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    apci_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pixel         (s_tdata),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .o_palette_index (palette_index),
        .o_match_kind    (match_kind)
    );

    assign m_tdata = {6'b0, match_kind, palette_index};

endmodule

@@ dv/testbench.sv @@
module testbench;
    import apci_pkg::*;

    localparam int N_ENTRIES   = 256;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 2000;
    localparam int SETTLE      = N_ENTRIES + 40;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [7:0] index;
        logic [1:0] kind;
    } t_color_code;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;   // pixel_red, pixel_green, pixel_blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // palette_index, match_kind, zero fill

    logic [7:0] pal_r [N_ENTRIES];
    logic [7:0] pal_g [N_ENTRIES];
    logic [7:0] pal_b [N_ENTRIES];
    int         pal_used = 0;

    t_color_code pending_codes [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_left = 0;
    logic hold_req = 1'b0;
    int  pixels_sent = 0;
    int  exact_count = 0;
    int  insert_count = 0;
    int  nearest_count = 0;
    int  tie_count = 0;

    adaptive_palette_color_indexer #(
        .PALETTE_ENTRIES(N_ENTRIES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_codes.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    function automatic int color_dist(input logic [7:0] r, g, b, input int i);
        int dr;
        int dg;
        int db;
        dr = int'(r) - int'(pal_r[i]);
        dg = int'(g) - int'(pal_g[i]);
        db = int'(b) - int'(pal_b[i]);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic t_color_code assign_palette_index(input logic [7:0] r, g, b);
        t_color_code code;
        int best_i;
        int best_d;
        int d;
        bit tied;
        for (int i = 0; i < pal_used; i++) begin
            if (pal_r[i] == r && pal_g[i] == g && pal_b[i] == b) begin
                code.index = 8'(i);
                code.kind = KIND_EXACT;
                exact_count++;
                return code;
            end
        end
        if (pal_used < N_ENTRIES) begin
            pal_r[pal_used] = r;
            pal_g[pal_used] = g;
            pal_b[pal_used] = b;
            code.index = 8'(pal_used);
            code.kind = KIND_INSERT;
            pal_used++;
            insert_count++;
            return code;
        end
        best_i = 0;
        best_d = color_dist(r, g, b, 0);
        tied = 1'b0;
        for (int i = 1; i < pal_used; i++) begin
            d = color_dist(r, g, b, i);
            if (d < best_d) begin
                best_d = d;
                best_i = i;
                tied = 1'b0;
            end else if (d == best_d) begin
                tied = 1'b1;
            end
        end
        if (tied) tie_count++;
        nearest_count++;
        code.index = 8'(best_i);
        code.kind = KIND_NEAREST;
        return code;
    endfunction

    // Checks each result beat and decides the next m_tready.
    always @(posedge i_clk) begin
        t_color_code want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: tdata=%h", m_tdata);
            end else begin
                want = pending_codes.pop_front();
                if (m_tdata[7:0] !== want.index || m_tdata[9:8] !== want.kind ||
                    m_tdata[15:10] !== 6'd0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: want index %0d kind %0d, got %0d kind %0d fill %h",
                                 want.index, want.kind, m_tdata[7:0], m_tdata[9:8],
                                 m_tdata[15:10]);
                end
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(input logic [7:0] r, g, b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
        pending_codes.push_back(assign_palette_index(r, g, b));
        pixels_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    function automatic logic [7:0] grid_level(input bit mid);
        return 8'($urandom_range(7) << 5) | (mid ? 8'd16 : 8'd0);
    endfunction

    task automatic send_existing();
        int k;
        k = $urandom_range(pal_used - 1);
        send_pixel(pal_r[k], pal_g[k], pal_b[k]);
    endtask

    task automatic test_directed_extremes();
        set_idling(0, 0);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        wait_results_done();
    endtask

    // Fill mostly with grid colors so that midpoints later give distance ties.
    task automatic test_fill_palette();
        int pick;
        set_idling(0, 0);
        while (pal_used < N_ENTRIES) begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_existing();
            else if (pick < 40)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_pixel(grid_level(1'b0), grid_level(1'b0), grid_level(1'b0));
        end
        wait_results_done();
    endtask

    task automatic test_full_palette();
        set_idling(0, 0);
        send_pixel(pal_r[N_ENTRIES - 1], pal_g[N_ENTRIES - 1], pal_b[N_ENTRIES - 1]);
        send_pixel(pal_r[0], pal_g[0], pal_b[0]);
        send_pixel(8'h01, 8'hFE, 8'h7F);
        send_pixel(8'hFE, 8'h01, 8'h80);
        for (int n = 0; n < 8; n++)
            send_pixel(grid_level(1'b1), grid_level(1'b1), grid_level(1'b0));
        send_pixel(8'h01, 8'hFE, 8'h7F);
        wait_results_done();
    endtask

    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
        int pick;
        set_idling(send_pct, recv_pct);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_existing();
            else if (pick < 60)
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 85)
                send_pixel(grid_level(1'($urandom_range(1))),
                           grid_level(1'($urandom_range(1))),
                           grid_level(1'($urandom_range(1))));
            else
                send_pixel(grid_level(1'b0), grid_level(1'b0), grid_level(1'b0));
        end
        wait_results_done();
    endtask

    // The receiver holds off while pixels keep arriving, so the input stalls.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int n = 0; n < 8; n++) begin
            if (n % 2 == 0)
                send_existing();
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_results_done();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_fill_palette();
        test_full_palette();
        test_random_mix(500, 0, 0);
        test_random_mix(500, 84, 0);
        test_random_mix(500, 0, 84);
        test_random_mix(500, 14, 14);
        test_backpressure();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d pixels: %0d exact, %0d inserted, %0d nearest (%0d with ties)",
                 pixels_sent, exact_count, insert_count, nearest_count, tie_count);
        $display("palette filled to %0d entries, %0d mismatches", pal_used, error_count);
        if (error_count == 0 && pending_codes.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
